// ===== sv/tmda_pkg.sv =====
// Shared types, constants and the color palette of the text-mode display adapter.
`timescale 1ns / 1ps

package tmda_pkg;

  // Text buffer window and geometry
  localparam int unsigned TEXT_BYTES  = 4096;
  localparam int unsigned COLUMNS     = 80;
  localparam int unsigned ROWS        = 25;
  localparam int unsigned GLYPHS      = 256;

  localparam int unsigned TEXT_AW     = $clog2(TEXT_BYTES);
  localparam int unsigned BANK_DEPTH  = (TEXT_BYTES + 1) / 2;
  localparam int unsigned BANK_AW     = $clog2(BANK_DEPTH);
  localparam int unsigned GLYPH_ROWS  = GLYPHS * 8;
  localparam int unsigned GLYPH_AW    = $clog2(GLYPH_ROWS);
  localparam int unsigned CELL_W      = 17;

  localparam logic [19:0] WIN_BASE    = 20'hb8000;
  localparam logic [19:0] STATUS_PORT = 20'h003da;
  localparam logic [15:0] STATUS_BITS = 16'h0009;

  // Command queue between front and back
  localparam int unsigned CQ_DEPTH    = 2;
  localparam int unsigned CQ_AW       = $clog2(CQ_DEPTH);
  localparam int unsigned CQ_CW       = $clog2(CQ_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_RD_BYTE = 3'd0,
    OP_RD_WORD = 3'd1,
    OP_WR_BYTE = 3'd2,
    OP_WR_WORD = 3'd3,
    OP_PORT_RD = 3'd4,
    OP_RENDER  = 3'd5,
    OP_GLYPH   = 3'd6
  } op_e;

  // Classified command kinds
  typedef enum logic [2:0] {
    K_NONE,
    K_RD_BYTE,
    K_RD_WORD,
    K_WRITE,
    K_PORT,
    K_RENDER,
    K_GLYPH
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_TEXT,
    ST_GLYPH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    kind_e                 kind;
    logic                  lo_odd;
    logic [BANK_AW-1:0]    even_row;
    logic [BANK_AW-1:0]    odd_row;
    logic                  we_even;
    logic                  we_odd;
    logic [7:0]            wd_even;
    logic [7:0]            wd_odd;
    logic [GLYPH_AW-1:0]   glyph_addr;
    logic [7:0]            glyph_data;
    logic [2:0]            bit_idx;
    logic [2:0]            glyph_row;
    logic                  ch_oob;
    logic                  at_oob;
  } cmd_t;

  // Back-end status toward the top level
  typedef struct packed {
    logic clearing;
    logic emit;
  } back_stat_t;

  function automatic logic [23:0] palette_bgr(input logic [3:0] idx);
    logic [23:0] c;
    unique case (idx)
      4'h0: c = 24'h000000;
      4'h1: c = 24'haa0000;
      4'h2: c = 24'h00aa00;
      4'h3: c = 24'haaaa00;
      4'h4: c = 24'h0000aa;
      4'h5: c = 24'haa00aa;
      4'h6: c = 24'h0055aa;
      4'h7: c = 24'haaaaaa;
      4'h8: c = 24'h555555;
      4'h9: c = 24'hff5555;
      4'ha: c = 24'h55ff55;
      4'hb: c = 24'hffff55;
      4'hc: c = 24'h5555ff;
      4'hd: c = 24'hff55ff;
      4'he: c = 24'h55ffff;
      4'hf: c = 24'hffffff;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/tmda_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module tmda_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on enable, register the read word every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tmda_front.sv =====
// Front end: accepts input beats and classifies them into back-end commands.
`timescale 1ns / 1ps

module tmda_front import tmda_pkg::*; (
  input  logic        push_i,
  input  logic [2:0]  opcode_i,
  input  logic [19:0] address_i,
  input  logic [15:0] write_data_i,
  input  logic [9:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  input  logic        cq_full_i,
  input  logic        clearing_i,
  output logic        full_o,
  output logic        cq_push_o,
  output cmd_t        cmd_o
);

  logic [19:0]       off20;
  logic              above;
  logic              win1;
  logic              win2;
  logic [6:0]        col;
  logic [4:0]        row;
  logic              on_screen;
  logic [CELL_W-1:0] cell_off;
  logic [TEXT_AW-1:0] off_sel;
  logic              is_render;
  logic              is_word;
  logic              lo;

  // Hold off input while the queue is full or the text buffer is being cleared
  assign full_o    = cq_full_i | clearing_i;
  assign cq_push_o = push_i & ~full_o;

  // Window checks for byte and word accesses
  assign off20 = address_i - WIN_BASE;
  assign above = address_i >= WIN_BASE;
  assign win1  = above && (off20 < 20'(TEXT_BYTES));
  assign win2  = above && (off20 < 20'(TEXT_BYTES - 1));

  // Cell lookup for a render request
  assign col       = pixel_x_i[9:3];
  assign row       = pixel_y_i[7:3];
  assign on_screen = ({3'b000, col} < 10'(COLUMNS)) && ({3'b000, row} < 8'(ROWS));
  assign cell_off  = CELL_W'(row) * CELL_W'(2 * COLUMNS) + CELL_W'({col, 1'b0});

  assign is_render = op_e'(opcode_i) == OP_RENDER;
  assign is_word   = op_e'(opcode_i) == OP_WR_WORD;
  assign off_sel   = is_render ? cell_off[TEXT_AW-1:0] : off20[TEXT_AW-1:0];
  assign lo        = off_sel[0];

  // Split the byte offset over the even and odd banks
  always_comb begin
    cmd_o            = '0;
    cmd_o.kind       = K_NONE;
    cmd_o.lo_odd     = lo;
    cmd_o.odd_row    = BANK_AW'(off_sel[TEXT_AW-1:1]);
    cmd_o.even_row   = BANK_AW'(off_sel[TEXT_AW-1:1]) + BANK_AW'(lo);
    cmd_o.we_even    = is_word | ~lo;
    cmd_o.we_odd     = is_word | lo;
    cmd_o.wd_even    = lo ? write_data_i[15:8] : write_data_i[7:0];
    cmd_o.wd_odd     = lo ? write_data_i[7:0]  : write_data_i[15:8];
    cmd_o.glyph_addr = address_i[GLYPH_AW-1:0];
    cmd_o.glyph_data = write_data_i[7:0];
    cmd_o.bit_idx    = pixel_x_i[2:0];
    cmd_o.glyph_row  = pixel_y_i[2:0];
    cmd_o.ch_oob     = cell_off >= CELL_W'(TEXT_BYTES);
    cmd_o.at_oob     = cell_off >= CELL_W'(TEXT_BYTES - 1);

    unique case (op_e'(opcode_i))
      OP_RD_BYTE: cmd_o.kind = win1 ? K_RD_BYTE : K_NONE;
      OP_RD_WORD: cmd_o.kind = win2 ? K_RD_WORD : K_NONE;
      OP_WR_BYTE: cmd_o.kind = win1 ? K_WRITE : K_NONE;
      OP_WR_WORD: cmd_o.kind = win2 ? K_WRITE : K_NONE;
      OP_PORT_RD: cmd_o.kind = (address_i == STATUS_PORT) ? K_PORT : K_NONE;
      OP_RENDER:  cmd_o.kind = on_screen ? K_RENDER : K_NONE;
      OP_GLYPH:   cmd_o.kind = (address_i < 20'(GLYPH_ROWS)) ? K_GLYPH : K_NONE;
      default:    cmd_o.kind = K_NONE;
    endcase
  end

endmodule

// ===== sv/tmda_cmdq.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module tmda_cmdq import tmda_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t             ent_q [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CQ_CW-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = cnt_q == CQ_CW'(CQ_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign cmd_o   = ent_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== sv/tmda_back.sv =====
// Back end: owns the text and glyph memories, clears the text memory and executes commands.
`timescale 1ns / 1ps

module tmda_back import tmda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        cq_empty_i,
  output logic        cq_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [15:0] read_data_o,
  output logic [23:0] pixel_color_o,
  output back_stat_t  stat_o
);

  state_e             state_q, state_d;
  logic [BANK_AW-1:0] clr_cnt_q, clr_cnt_d;
  cmd_t               cur_q;
  logic               toggle_q, toggle_d;
  logic [15:0]        res_rd_q, res_rd_d;
  logic [23:0]        res_px_q, res_px_d;
  logic               out_valid_q, out_valid_d;
  logic [15:0]        out_rd_q;
  logic [23:0]        out_px_q;

  logic               clearing;
  logic               clr_last;
  logic               slot_free;
  logic               out_load;
  logic               cur_load;

  logic               we_even, we_odd, we_glyph;
  logic [BANK_AW-1:0] addr_even, addr_odd;
  logic [7:0]         wd_even, wd_odd;
  logic [7:0]         rd_even, rd_odd;
  logic [GLYPH_AW-1:0] addr_glyph;
  logic [7:0]         rd_glyph;
  logic [7:0]         ch;
  logic [7:0]         attr;
  logic               fg;

  assign clearing  = state_q == ST_CLEAR;
  assign clr_last  = clr_cnt_q == BANK_AW'(BANK_DEPTH - 1);
  assign slot_free = ~out_valid_q | pop_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (!cq_empty_i) state_d = ST_EXEC;
      ST_EXEC: begin
        if (cur_q.kind == K_RD_BYTE || cur_q.kind == K_RD_WORD ||
            cur_q.kind == K_RENDER) begin
          state_d = ST_TEXT;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_TEXT:  state_d = (cur_q.kind == K_RENDER) ? ST_GLYPH : ST_EMIT;
      ST_GLYPH: state_d = ST_EMIT;
      ST_EMIT:  if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Memory controls: clearing sweep first, then the current command
  assign ch         = cur_q.ch_oob ? 8'h00 : rd_even;
  assign attr       = cur_q.at_oob ? 8'h00 : rd_odd;
  assign addr_even  = clearing ? clr_cnt_q : cur_q.even_row;
  assign addr_odd   = clearing ? clr_cnt_q : cur_q.odd_row;
  assign wd_even    = clearing ? 8'h00 : cur_q.wd_even;
  assign wd_odd     = clearing ? 8'h00 : cur_q.wd_odd;
  assign addr_glyph = (state_q == ST_EXEC) ? cur_q.glyph_addr : {ch, cur_q.glyph_row};
  assign fg         = rd_glyph[~cur_q.bit_idx];

  // Outputs of the sequencer
  always_comb begin
    cq_pop_o  = 1'b0;
    cur_load  = 1'b0;
    out_load  = 1'b0;
    we_even   = clearing;
    we_odd    = clearing;
    we_glyph  = 1'b0;
    clr_cnt_d = clr_cnt_q;
    toggle_d  = toggle_q;
    res_rd_d  = res_rd_q;
    res_px_d  = res_px_q;
    unique case (state_q)
      ST_CLEAR: clr_cnt_d = clr_cnt_q + 1'b1;
      ST_IDLE: begin
        cq_pop_o = ~cq_empty_i;
        cur_load = ~cq_empty_i;
      end
      ST_EXEC: begin
        res_rd_d = '0;
        res_px_d = '0;
        we_even  = (cur_q.kind == K_WRITE) & cur_q.we_even;
        we_odd   = (cur_q.kind == K_WRITE) & cur_q.we_odd;
        we_glyph = cur_q.kind == K_GLYPH;
        if (cur_q.kind == K_PORT) begin
          toggle_d = ~toggle_q;
          res_rd_d = toggle_q ? 16'h0000 : STATUS_BITS;
        end
      end
      ST_TEXT: begin
        if (cur_q.kind == K_RD_BYTE) begin
          res_rd_d = {8'h00, cur_q.lo_odd ? rd_odd : rd_even};
        end else if (cur_q.kind == K_RD_WORD) begin
          res_rd_d = cur_q.lo_odd ? {rd_even, rd_odd} : {rd_odd, rd_even};
        end
      end
      ST_GLYPH: res_px_d = palette_bgr(fg ? attr[3:0] : attr[7:4]);
      ST_EMIT:  out_load = slot_free;
      default: ;
    endcase
  end

  // Result slot: load on emit, drop on pop
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      toggle_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      toggle_q    <= toggle_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_load) begin
      cur_q <= cmd_i;
    end
    res_rd_q <= res_rd_d;
    res_px_q <= res_px_d;
    if (out_load) begin
      out_rd_q <= res_rd_q;
      out_px_q <= res_px_q;
    end
  end

  tmda_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_text_even (
    .clk_i  (clk_i),
    .we_i   (we_even),
    .addr_i (addr_even),
    .wdata_i(wd_even),
    .rdata_o(rd_even)
  );

  tmda_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_text_odd (
    .clk_i  (clk_i),
    .we_i   (we_odd),
    .addr_i (addr_odd),
    .wdata_i(wd_odd),
    .rdata_o(rd_odd)
  );

  tmda_ram #(.WIDTH(8), .DEPTH(GLYPH_ROWS)) u_glyph (
    .clk_i  (clk_i),
    .we_i   (we_glyph),
    .addr_i (addr_glyph),
    .wdata_i(cur_q.glyph_data),
    .rdata_o(rd_glyph)
  );

  assign empty_o         = ~out_valid_q;
  assign read_data_o     = out_rd_q;
  assign pixel_color_o   = out_px_q;
  assign stat_o.clearing = clearing;
  assign stat_o.emit     = out_load;

endmodule

// ===== sv/text_mode_display_adapter_core.sv =====
// Each accepted command is queued, then stepped through EXEC, TEXT (reads, renders), GLYPH (renders) and EMIT.
// The back-end sequencer takes a new command only once the result of the last one has been emitted.
// A two-entry command queue and a one-entry result slot let each side stall on its own.
// After reset the text buffer is swept to zero with full_o held high.
// The glyph store is not cleared; the status toggle resets to zero.
`timescale 1ns / 1ps

module text_mode_display_adapter_core import tmda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  opcode_i,
  input  logic [19:0] address_i,
  input  logic [15:0] write_data_i,
  input  logic [9:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] read_data_o,
  output logic [23:0] pixel_color_o
);

  cmd_t       front_cmd;
  cmd_t       head_cmd;
  logic       cq_push;
  logic       cq_pop;
  logic       cq_full;
  logic       cq_empty;
  back_stat_t stat;

  tmda_front u_front (
    .push_i      (push),
    .opcode_i    (opcode_i),
    .address_i   (address_i),
    .write_data_i(write_data_i),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .cq_full_i   (cq_full),
    .clearing_i  (stat.clearing),
    .full_o      (full),
    .cq_push_o   (cq_push),
    .cmd_o       (front_cmd)
  );

  tmda_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cq_push),
    .cmd_i  (front_cmd),
    .pop_i  (cq_pop),
    .cmd_o  (head_cmd),
    .full_o (cq_full),
    .empty_o(cq_empty)
  );

  tmda_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (head_cmd),
    .cq_empty_i   (cq_empty),
    .cq_pop_o     (cq_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .read_data_o  (read_data_o),
    .pixel_color_o(pixel_color_o),
    .stat_o       (stat)
  );

  // No beat is taken while the text buffer sweep runs
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> full)
    else $error("input accepted during text buffer clear");

  // No result appears while clearing
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> empty)
    else $error("result present during text buffer clear");

  // A result shows up only after the back end emitted one
  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(stat.emit))
    else $error("result slot filled without an emit");

  // The back end takes a command only when one is queued
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_pop |-> !cq_empty)
    else $error("command queue popped while empty");

endmodule

// ===== tb/display_adapter_checker.sv =====
// Checker for the display adapter: predicts each command beat and compares result beats.
`timescale 1ns / 1ps

module display_adapter_checker import tmda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [2:0]  opcode_i,
  input  logic [19:0] address_i,
  input  logic [15:0] write_data_i,
  input  logic [9:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [15:0] read_data_i,
  input  logic [23:0] pixel_color_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] read_data;
    logic [23:0] pixel_color;
  } answer_t;

  logic [7:0] text_shadow  [TEXT_BYTES];
  logic [7:0] glyph_shadow [GLYPH_ROWS];
  logic       sync_flag;
  answer_t    answers_due [$];
  int         mismatches = 0;

  // Build the BGR color of a palette index: each primary adds 0xaa, intensity
  // adds 0x55 to all three, and plain brown gets only half its green.
  function automatic logic [23:0] index_to_bgr(input logic [3:0] idx);
    logic [7:0] lift, blue, green, red;
    lift  = idx[3] ? 8'h55 : 8'h00;
    blue  = idx[0] ? 8'haa : 8'h00;
    green = (idx == 4'h6) ? 8'h55 : (idx[1] ? 8'haa : 8'h00);
    red   = idx[2] ? 8'haa : 8'h00;
    return {blue + lift, green + lift, red + lift};
  endfunction

  // Apply one accepted command to the shadow state and return its answer
  task automatic run_command(input logic [2:0] op, input logic [19:0] addr,
                             input logic [15:0] data, input logic [9:0] px,
                             input logic [7:0] py, output answer_t ans);
    int unsigned off, cell_idx, col, row, gidx;
    logic        byte_ok, word_ok;
    logic [7:0]  ch, attr, bits;
    ans     = '0;
    off     = addr - WIN_BASE;
    byte_ok = (addr >= WIN_BASE) && (off < TEXT_BYTES);
    word_ok = (addr >= WIN_BASE) && (off + 2 <= TEXT_BYTES);
    case (op)
      OP_RD_BYTE: if (byte_ok) ans.read_data = {8'h00, text_shadow[off]};
      OP_RD_WORD: if (word_ok) ans.read_data = {text_shadow[off + 1], text_shadow[off]};
      OP_WR_BYTE: if (byte_ok) text_shadow[off] = data[7:0];
      OP_WR_WORD: if (word_ok) begin
        text_shadow[off]     = data[7:0];
        text_shadow[off + 1] = data[15:8];
      end
      OP_PORT_RD: if (addr == STATUS_PORT) begin
        sync_flag     = ~sync_flag;
        ans.read_data = sync_flag ? STATUS_BITS : 16'h0000;
      end
      OP_RENDER: begin
        col = px >> 3;
        row = py >> 3;
        // Off-screen pixels stay black
        if (col < COLUMNS && row < ROWS) begin
          cell_idx = row * 2 * COLUMNS + 2 * col;
          ch   = (cell_idx < TEXT_BYTES) ? text_shadow[cell_idx] : 8'h00;
          attr = (cell_idx + 1 < TEXT_BYTES) ? text_shadow[cell_idx + 1] : 8'h00;
          gidx = ch * 8 + py[2:0];
          bits = (gidx < GLYPH_ROWS) ? glyph_shadow[gidx] : 8'h00;
          ans.pixel_color = index_to_bgr(bits[3'd7 - px[2:0]] ? attr[3:0] : attr[7:4]);
        end
      end
      OP_GLYPH: if (addr < GLYPH_ROWS) glyph_shadow[addr] = data[7:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    answer_t due;
    if (!rst_ni) begin
      foreach (text_shadow[i]) text_shadow[i] = 8'h00;
      foreach (glyph_shadow[i]) glyph_shadow[i] = 8'h00;
      sync_flag = 1'b0;
      answers_due.delete();
    end else begin
      // Predict each command beat as the adapter takes it
      if (push_i && !full_i) begin
        run_command(opcode_i, address_i, write_data_i, pixel_x_i, pixel_y_i, due);
        answers_due.push_back(due);
      end
      // Compare each result beat with the oldest prediction
      if (pop_i && !empty_i) begin
        if (answers_due.size() == 0) begin
          $error("result beat with no command outstanding: read_data %h, pixel_color %h",
                 read_data_i, pixel_color_i);
          mismatches++;
        end else begin
          due = answers_due.pop_front();
          if (read_data_i !== due.read_data) begin
            $error("read_data: expected %h, actual %h", due.read_data, read_data_i);
            mismatches++;
          end
          if (pixel_color_i !== due.pixel_color) begin
            $error("pixel_color: expected %h, actual %h", due.pixel_color, pixel_color_i);
            mismatches++;
          end
        end
      end
    end
    fail_cnt_o <= mismatches;
    pending_o  <= answers_due.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top: drives command beats and result pops on the display adapter, gives the verdict.
`timescale 1ns / 1ps

module tb;
  import tmda_pkg::*;

  localparam logic [2:0]  OP_UNUSED    = 3'd7;
  localparam logic [19:0] WIN_LAST     = WIN_BASE + 20'(TEXT_BYTES - 1);
  localparam int unsigned FOCUS_BYTES  = 4 * COLUMNS;  // first two text rows
  localparam int unsigned RANDOM_ITEMS = 1200;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        push         = 1'b0;
  logic        full;
  logic [2:0]  opcode_i     = '0;
  logic [19:0] address_i    = '0;
  logic [15:0] write_data_i = '0;
  logic [9:0]  pixel_x_i    = '0;
  logic [7:0]  pixel_y_i    = '0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [15:0] read_data_o;
  logic [23:0] pixel_color_o;
  logic        quiet        = 1'b0;
  int          fail_cnt;
  int          pending;

  // Characters the adapter holds and glyph rows loaded so far, to keep renders legal
  bit [7:0] char_image   [TEXT_BYTES];
  bit       glyph_loaded [GLYPH_ROWS];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  text_mode_display_adapter_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .opcode_i     (opcode_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .empty        (empty),
    .pop          (pop),
    .read_data_o  (read_data_o),
    .pixel_color_o(pixel_color_o)
  );

  display_adapter_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .opcode_i     (opcode_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .empty_i      (empty),
    .pop_i        (pop),
    .read_data_i  (read_data_o),
    .pixel_color_i(pixel_color_o),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending)
  );

  // Stall the result side at random, except during the quiet stretch
  always @(posedge clk_i) begin
    pop <= quiet || ($urandom_range(99) >= 26);
  end

  // Present one command beat, hold it until taken, then track its effect
  task automatic push_beat(input logic [2:0] op, input logic [19:0] addr,
                           input logic [15:0] data, input logic [9:0] px,
                           input logic [7:0] py);
    int unsigned off;
    while (!quiet && $urandom_range(99) < 26) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    opcode_i     <= op;
    address_i    <= addr;
    write_data_i <= data;
    pixel_x_i    <= px;
    pixel_y_i    <= py;
    do @(posedge clk_i); while (full);
    off = addr - WIN_BASE;
    if (op == OP_WR_BYTE && addr >= WIN_BASE && off < TEXT_BYTES)
      char_image[off] = data[7:0];
    if (op == OP_WR_WORD && addr >= WIN_BASE && off + 2 <= TEXT_BYTES) begin
      char_image[off]     = data[7:0];
      char_image[off + 1] = data[15:8];
    end
    if (op == OP_GLYPH && addr < GLYPH_ROWS)
      glyph_loaded[addr] = 1'b1;
  endtask

  // Send a command; ahead of a render whose glyph row was never loaded, load it first
  task automatic issue(input logic [2:0] op, input logic [19:0] addr,
                       input logic [15:0] data, input logic [9:0] px,
                       input logic [7:0] py);
    int unsigned cell_idx, gidx;
    if (op == OP_RENDER && px < COLUMNS * 8 && py < ROWS * 8) begin
      cell_idx = (py / 8) * 2 * COLUMNS + 2 * (px / 8);
      gidx = char_image[cell_idx] * 8 + py[2:0];
      if (!glyph_loaded[gidx])
        push_beat(OP_GLYPH, gidx[19:0], 16'($urandom_range(16'hffff)),
                  10'($urandom_range(10'h3ff)), 8'($urandom_range(8'hff)));
    end
    push_beat(op, addr, data, px, py);
  endtask

  // Mostly the first text rows, then the whole window, its edges and anywhere
  function automatic logic [19:0] pick_address();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 70) return WIN_BASE + 20'($urandom_range(FOCUS_BYTES - 1));
    if (k < 85) return WIN_BASE + 20'($urandom_range(TEXT_BYTES - 1));
    if (k < 90) begin
      case ($urandom_range(3))
        0:       return WIN_BASE - 20'd1;
        1:       return WIN_LAST - 20'd1;
        2:       return WIN_LAST;
        default: return WIN_LAST + 20'd1;
      endcase
    end
    return 20'($urandom_range(20'hfffff));
  endfunction

  // Mostly pixels over the first text rows, some anywhere on or off screen
  task automatic pick_pixel(output logic [9:0] px, output logic [7:0] py);
    int unsigned k;
    k = $urandom_range(99);
    if (k < 70) begin
      px = 10'($urandom_range(COLUMNS * 8 - 1));
      py = 8'($urandom_range(15));
    end else if (k < 90) begin
      px = 10'($urandom_range(COLUMNS * 8 - 1));
      py = 8'($urandom_range(ROWS * 8 - 1));
    end else begin
      px = 10'($urandom_range(10'h3ff));
      py = 8'($urandom_range(8'hff));
    end
  endtask

  initial begin : stimulus
    logic [2:0]  op;
    logic [19:0] addr;
    logic [15:0] data;
    logic [9:0]  px;
    logic [7:0]  py;
    int unsigned k;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Cleared buffer, then accesses at both ends of the window and just outside it
    issue(OP_RD_BYTE, WIN_BASE, 16'hffff, 10'd0, 8'd0);
    issue(OP_RD_WORD, WIN_LAST - 20'd1, 16'h0000, 10'd0, 8'd0);
    issue(OP_WR_WORD, WIN_BASE, 16'h1f41, 10'd0, 8'd0);
    issue(OP_RD_WORD, WIN_BASE, 16'h0000, 10'd0, 8'd0);
    issue(OP_WR_BYTE, WIN_LAST, 16'hffa5, 10'd0, 8'd0);
    issue(OP_RD_BYTE, WIN_LAST, 16'h0000, 10'd0, 8'd0);
    issue(OP_WR_WORD, WIN_LAST, 16'hffff, 10'd0, 8'd0);
    issue(OP_RD_WORD, WIN_LAST, 16'h0000, 10'd0, 8'd0);
    issue(OP_RD_WORD, WIN_LAST - 20'd1, 16'h0000, 10'd0, 8'd0);
    issue(OP_WR_BYTE, WIN_BASE - 20'd1, 16'hffff, 10'd0, 8'd0);
    issue(OP_RD_BYTE, WIN_BASE - 20'd1, 16'h0000, 10'd0, 8'd0);
    issue(OP_WR_WORD, WIN_LAST + 20'd1, 16'hffff, 10'd0, 8'd0);
    issue(OP_RD_BYTE, WIN_LAST + 20'd1, 16'h0000, 10'd0, 8'd0);
    issue(OP_RD_WORD, 20'hfffff, 16'h0000, 10'd0, 8'd0);
    // Status toggles on each read of its own port only
    repeat (3) issue(OP_PORT_RD, STATUS_PORT, 16'h0000, 10'd0, 8'd0);
    issue(OP_PORT_RD, STATUS_PORT + 20'd1, 16'h0000, 10'd0, 8'd0);
    // Row 0 of glyph 0x41, then loads beyond the glyph store
    issue(OP_GLYPH, 20'h00208, 16'hff81, 10'd0, 8'd0);
    issue(OP_GLYPH, 20'(GLYPH_ROWS), 16'hffff, 10'd0, 8'd0);
    issue(OP_GLYPH, 20'hfffff, 16'hffff, 10'd0, 8'd0);
    // Foreground and background bits of cell 0, then pixels off screen
    issue(OP_RENDER, 20'h00000, 16'h0000, 10'd0, 8'd0);
    issue(OP_RENDER, 20'h00000, 16'h0000, 10'd1, 8'd0);
    issue(OP_RENDER, 20'h00000, 16'h0000, 10'd7, 8'd0);
    issue(OP_RENDER, 20'h00000, 16'h0000, 10'(COLUMNS * 8), 8'd0);
    issue(OP_RENDER, 20'h00000, 16'h0000, 10'd0, 8'(ROWS * 8));
    issue(OP_RENDER, 20'hfffff, 16'hffff, 10'h3ff, 8'hff);
    issue(OP_UNUSED, 20'hfffff, 16'hffff, 10'h3ff, 8'hff);

    // Random mix, with a stretch where neither side idles
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet <= (n >= 500 && n < 700);
      pick_pixel(px, py);
      addr = pick_address();
      data = 16'($urandom_range(16'hffff));
      k    = $urandom_range(99);
      if (k < 10) op = OP_RD_BYTE;
      else if (k < 20) op = OP_RD_WORD;
      else if (k < 38) op = OP_WR_BYTE;
      else if (k < 52) op = OP_WR_WORD;
      else if (k < 58) begin
        op = OP_PORT_RD;
        if ($urandom_range(4) != 0) addr = STATUS_PORT;
      end else if (k < 84) op = OP_RENDER;
      else if (k < 94) begin
        op   = OP_GLYPH;
        addr = ($urandom_range(9) != 0) ? 20'($urandom_range(GLYPH_ROWS - 1))
                                        : 20'($urandom_range(20'hfffff));
      end else if (k < 97) op = OP_UNUSED;
      else begin
        op   = 3'($urandom_range(7));
        addr = 20'($urandom_range(20'hfffff));
      end
      issue(op, addr, data, px, py);
    end

    // Drain all results, then let the pipeline settle before giving the verdict
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
